@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: serial frame receiver shared types and constants
// Item layouts for the receive and result channels, header codes and the
// frame status codes.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // header and marker bytes
    localparam logic [7:0] HdrShort = 8'hAA;
    localparam logic [7:0] HdrLong  = 8'hBB;
    localparam logic [7:0] CardGone = 8'hEA;

    // reset value of the short length limit
    localparam logic [7:0] ShortLimitReset = 8'd50;

    // frame status codes
    typedef logic [2:0] t_status;
    localparam t_status StShortOk   = 3'd0;
    localparam t_status StLongOk    = 3'd1;
    localparam t_status StCardGone  = 3'd2;
    localparam t_status StBadHeader = 3'd3;
    localparam t_status StShortZero = 3'd4;
    localparam t_status StShortBad  = 3'd5;
    localparam t_status StLongBad   = 3'd6;
    localparam t_status StCheckBad  = 3'd7;

    // received item
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    // result item
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       frame_kind;
        t_status    status;
    } t_res_item;

endpackage
`default_nettype wire

@@ sv/sfr_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_stream_if: valid/ready item channel
// Carries one item of type T per accepted handshake.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/sfr_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_in_stage: receive item register
// Registers each received byte; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module sfr_in_stage (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfr_stream_if.sink   i_rx,
    sfr_stream_if.source o_rx
);

    logic              r_valid;
    sfr_pkg::t_rx_item r_data;
    logic              w_load;

    // take a new item when empty or when the held one leaves
    assign i_rx.ready = !r_valid || o_rx.ready;
    assign w_load     = i_rx.valid && i_rx.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_rx.data;
        end
    end

    assign o_rx.valid = r_valid;
    assign o_rx.data  = r_data;

endmodule
`default_nettype wire

@@ sv/sfr_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_step: frame parser state and per-byte decode
// Decodes one byte against the frame state, forms its result item and
// advances the state when the item moves on.
// ----------------------------------------------------------------------------
module sfr_step #(
    parameter int unsigned BUFFER_BYTES = 4096
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    sfr_stream_if.sink      i_rx,
    sfr_stream_if.source    o_res
);

    // parser phases
    localparam logic [2:0] PhWait  = 3'd0;
    localparam logic [2:0] PhSlen  = 3'd1;
    localparam logic [2:0] PhSpay  = 3'd2;
    localparam logic [2:0] PhLhi   = 3'd3;
    localparam logic [2:0] PhLlo   = 3'd4;
    localparam logic [2:0] PhLpay  = 3'd5;
    localparam logic [2:0] PhCheck = 3'd6;

    // largest frame that fits, compared against length plus four
    localparam logic [16:0] BufLimit = 17'(BUFFER_BYTES);

    logic [7:0]  r_short_len_limit;
    logic [2:0]  r_phase,        n_phase;
    logic        r_is_long,      n_is_long;
    logic [7:0]  r_short_length, n_short_length;
    logic [7:0]  r_length_high,  n_length_high;
    logic [15:0] r_bytes_left,   n_bytes_left;
    logic [7:0]  r_running_xor,  n_running_xor;

    logic                w_step;
    logic [7:0]          w_byte;
    logic [15:0]         w_left_dec;
    logic [15:0]         w_long_len;
    logic                w_long_bad;
    sfr_pkg::t_res_item  w_res;

    assign w_step     = i_rx.valid && o_res.ready;
    assign w_byte     = i_rx.data.rx_byte;
    assign w_left_dec = r_bytes_left - 16'd1;
    assign w_long_len = {r_length_high, w_byte};
    assign w_long_bad = (w_long_len == 16'd0)
                     || (({1'b0, w_long_len} + 17'd4) > BufLimit);

    // per-byte decode
    always_comb begin
        n_phase        = r_phase;
        n_is_long      = r_is_long;
        n_short_length = r_short_length;
        n_length_high  = r_length_high;
        n_bytes_left   = r_bytes_left;
        n_running_xor  = r_running_xor;

        w_res.frame_byte = w_byte;
        w_res.byte_valid = 1'b1;
        w_res.frame_end  = 1'b0;
        w_res.frame_kind = r_is_long;
        w_res.status     = sfr_pkg::StShortOk;

        case (r_phase)
            PhSlen: begin
                n_short_length = w_byte;
                if (w_byte == 8'd0) begin
                    w_res.frame_end = 1'b1;
                    w_res.status    = sfr_pkg::StShortZero;
                    n_phase         = PhWait;
                end else begin
                    n_bytes_left = {8'd0, w_byte};
                    n_phase      = PhSpay;
                end
            end
            PhSpay: begin
                n_bytes_left = w_left_dec;
                if (w_left_dec == 16'd0) begin
                    w_res.frame_end = 1'b1;
                    if (r_short_length == 8'd1 && w_byte == sfr_pkg::CardGone) begin
                        w_res.status = sfr_pkg::StCardGone;
                    end else if (r_short_length > 8'd1
                                 && r_short_length < r_short_len_limit) begin
                        w_res.status = sfr_pkg::StShortOk;
                    end else begin
                        w_res.status = sfr_pkg::StShortBad;
                    end
                    n_phase = PhWait;
                end
            end
            PhLhi: begin
                n_length_high = w_byte;
                n_running_xor = r_running_xor ^ w_byte;
                n_phase       = PhLlo;
            end
            PhLlo: begin
                n_running_xor = r_running_xor ^ w_byte;
                if (w_long_bad) begin
                    w_res.frame_end = 1'b1;
                    w_res.status    = sfr_pkg::StLongBad;
                    n_phase         = PhWait;
                end else begin
                    n_bytes_left = w_long_len;
                    n_phase      = PhLpay;
                end
            end
            PhLpay: begin
                n_running_xor = r_running_xor ^ w_byte;
                n_bytes_left  = w_left_dec;
                if (w_left_dec == 16'd0) begin
                    n_phase = PhCheck;
                end
            end
            PhCheck: begin
                w_res.frame_end = 1'b1;
                w_res.status    = (w_byte == r_running_xor) ? sfr_pkg::StLongOk
                                                            : sfr_pkg::StCheckBad;
                n_phase         = PhWait;
            end
            default: begin
                // waiting for a header, unused codes land here too
                n_phase = PhWait;
                if (w_byte == sfr_pkg::HdrShort) begin
                    n_is_long        = 1'b0;
                    w_res.frame_kind = 1'b0;
                    n_phase          = PhSlen;
                end else if (w_byte == sfr_pkg::HdrLong) begin
                    n_is_long        = 1'b1;
                    w_res.frame_kind = 1'b1;
                    n_running_xor    = w_byte;
                    n_phase          = PhLhi;
                end else begin
                    w_res.byte_valid = 1'b0;
                    w_res.frame_end  = 1'b1;
                    w_res.frame_kind = 1'b0;
                    w_res.status     = sfr_pkg::StBadHeader;
                end
            end
        endcase
    end

    // short length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_len_limit <= sfr_pkg::ShortLimitReset;
        end else if (i_cfg_we) begin
            r_short_len_limit <= i_cfg_wdata;
        end
    end

    // frame state, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PhWait;
            r_is_long      <= 1'b0;
            r_short_length <= 8'd0;
            r_length_high  <= 8'd0;
            r_bytes_left   <= 16'd0;
            r_running_xor  <= 8'd0;
        end else if (w_step) begin
            r_phase        <= n_phase;
            r_is_long      <= n_is_long;
            r_short_length <= n_short_length;
            r_length_high  <= n_length_high;
            r_bytes_left   <= n_bytes_left;
            r_running_xor  <= n_running_xor;
        end
    end

    assign i_rx.ready  = o_res.ready;
    assign o_res.valid = i_rx.valid;
    assign o_res.data  = w_res;

endmodule
`default_nettype wire

@@ sv/sfr_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_out_stage: result item register
// Holds one result item until taken; reloads in the cycle it is drained.
// ----------------------------------------------------------------------------
module sfr_out_stage (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sfr_stream_if.sink   i_res,
    sfr_stream_if.source o_res
);

    logic               r_valid;
    sfr_pkg::t_res_item r_data;
    logic               w_load;

    // load when empty or when the held item is taken
    assign i_res.ready = !r_valid || o_res.ready;
    assign w_load      = i_res.valid && i_res.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.ready) begin
            r_valid <= i_res.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_res.data;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_data;

endmodule
`default_nettype wire

@@ sv/serial_frame_receiver_xor_check_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor_check_unit: serial frame receiver top level
// Parses short (0xAA) and long (0xBB, XOR checked) frames byte by byte and
// returns one result item per received byte.
//
//   channel   dir   handshake            payload
//   i_rx      in    valid / ready        rx_byte
//   o_res     out   valid / ready        frame_byte, byte_valid, frame_end,
//                                        frame_kind, status
//   cfg       in    i_cfg_we             i_cfg_wdata = short_len_limit
//
// One item per cycle sustained while o_res is ready; each result passes
// through the receive register, then is decoded into the result register,
// from which it is taken.
// Synchronous active-low reset clears the frame state, empties both
// registers and sets the short length limit to 50.
// A stalled result holds in the result register while one more byte waits
// in the receive register; ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module serial_frame_receiver_xor_check_unit #(
    parameter int unsigned BUFFER_BYTES = 4096
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    sfr_stream_if.sink      i_rx,
    sfr_stream_if.source    o_res
);

    sfr_stream_if #(.T(sfr_pkg::t_rx_item))  w_rx_q ();
    sfr_stream_if #(.T(sfr_pkg::t_res_item)) w_res_d ();

    // receive register
    sfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_rx    (w_rx_q)
    );

    // decode and frame state
    sfr_step #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (w_rx_q),
        .o_res       (w_res_d)
    );

    // result register
    sfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res_d),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
